// ===== rtl/xsx_pkg.sv =====
// Shared types, opcodes and helpers for the x86 subset execute core.
`default_nettype none
package xsx_pkg;

  localparam int unsigned PTR_W  = 20;
  localparam int unsigned REG_W  = 16;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned NREGS  = 8;

  localparam logic [PTR_W-1:0] PTR_RESET = 20'hFE000;

  localparam logic [REG_W-1:0] FLAG_CF = 16'h0001;
  localparam logic [REG_W-1:0] FLAG_ZF = 16'h0040;
  localparam logic [REG_W-1:0] FLAG_SF = 16'h0080;
  localparam logic [REG_W-1:0] FLAG_OF = 16'h0800;
  localparam logic [REG_W-1:0] SIGN_BIT = 16'h8000;

  // Opcodes
  localparam logic [7:0] OP_ADD_RR  = 8'h01;
  localparam logic [7:0] OP_ADD_AX  = 8'h05;
  localparam logic [7:0] OP_SUB_AX  = 8'h2D;
  localparam logic [7:0] OP_XOR_RR  = 8'h31;
  localparam logic [7:0] OP_CMP_RR  = 8'h39;
  localparam logic [7:0] OP_INC_LO  = 8'h40;
  localparam logic [7:0] OP_DEC_LO  = 8'h48;
  localparam logic [7:0] OP_DEC_HI  = 8'h4F;
  localparam logic [7:0] OP_JE      = 8'h74;
  localparam logic [7:0] OP_GRP_I16 = 8'h81;
  localparam logic [7:0] OP_GRP_I8  = 8'h83;
  localparam logic [7:0] OP_NOP     = 8'h90;
  localparam logic [7:0] OP_MOV_LO  = 8'hB8;
  localparam logic [7:0] OP_MOV_HI  = 8'hBF;
  localparam logic [7:0] OP_JMP     = 8'hEB;
  localparam logic [7:0] OP_HLT     = 8'hF4;

  // Group modrm ranges
  localparam logic [7:0] MODRM_ADD_LO = 8'hC0;
  localparam logic [7:0] MODRM_ADD_HI = 8'hC7;
  localparam logic [7:0] MODRM_SUB_LO = 8'hE8;
  localparam logic [7:0] MODRM_SUB_HI = 8'hEF;
  localparam logic [1:0] MOD_REG      = 2'b11;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_HALT    = 3'd1,
    ST_BAD_OP  = 3'd2,
    ST_BAD_MOD = 3'd3,
    ST_BAD_EXT = 3'd4,
    ST_STOPPED = 3'd5
  } status_t;

  // Architectural state update and result of one instruction
  typedef struct packed {
    status_t           status;
    logic [PTR_W-1:0]  next_ptr;
    logic [2:0]        used;
    logic              we;
    logic [IDX_W-1:0]  widx;
    logic [REG_W-1:0]  wval;
    logic [REG_W-1:0]  flags;
    logic              running;
  } exec_res_t;

  // Destination register of an instruction, taken from opcode or modrm (register 0 for the AX forms)
  function automatic logic [IDX_W-1:0] dst_index(input logic [7:0] op, input logic [7:0] b1);
    logic [IDX_W-1:0] idx;
    idx = op[IDX_W-1:0];
    if (op == OP_ADD_RR || op == OP_XOR_RR || op == OP_CMP_RR ||
        op == OP_GRP_I16 || op == OP_GRP_I8) begin
      idx = b1[IDX_W-1:0];
    end else if (op == OP_ADD_AX || op == OP_SUB_AX) begin
      idx = '0;
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/x86_subset_instruction_execute_core.sv =====
// Top level of the x86 16-bit subset execute core.
// Usage:
//   Input channel (in_valid/in_ready) carries the four instruction bytes
//   fetched at the current instruction pointer; result channel
//   (out_valid/out_ready) returns status, next pointer, bytes consumed,
//   the register write (if any) and the flags word after the instruction.
// Pipeline: the bytes land in an input register at the accepting edge
//   while the two source/destination registers are read from the
//   register file; the instruction then executes and loads the result
//   register as it leaves the input stage, and out_valid rises with it.
// Throughput: one instruction per cycle while out_ready is high. The
//   architectural state (registers, flags, pointer, running flag) updates
//   as the instruction moves into the result register; the register file
//   bypasses that write to the next read, so dependents follow back to back.
// Reset: registers and flags clear, pointer loads 0xFE000, the core runs.
//   After halt or a fault every further item returns status "stopped".
// Stall: when out_ready is low the result holds; one more item may wait in
//   the input register, after which in_ready drops until the result drains.
`default_nettype none
module x86_subset_instruction_execute_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [7:0]                  in_opcode_byte,
  input  wire logic [7:0]                  in_next_byte_one,
  input  wire logic [7:0]                  in_next_byte_two,
  input  wire logic [7:0]                  in_next_byte_three,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [2:0]                  out_status,
  output logic      [xsx_pkg::PTR_W-1:0]   out_next_pointer,
  output logic      [2:0]                  out_bytes_used,
  output logic                             out_write_enable,
  output logic      [xsx_pkg::IDX_W-1:0]   out_write_index,
  output logic      [xsx_pkg::REG_W-1:0]   out_write_value,
  output logic      [xsx_pkg::REG_W-1:0]   out_flags_word
);
  import xsx_pkg::*;

  // Input stage
  logic             s1_valid_r, s1_valid_nxt;
  logic [7:0]       s1_op_r, s1_b1_r, s1_b2_r, s1_b3_r;
  logic             in_fire;
  logic             s1_adv;
  logic             s1_fire;

  // Architectural state
  logic [PTR_W-1:0] ip_r;
  logic [REG_W-1:0] flags_r;
  logic             running_r;

  // Register file read data for the instruction in the input stage
  logic [REG_W-1:0] src_val;
  logic [REG_W-1:0] dst_val;

  exec_res_t        res;

  // Result register
  logic             out_valid_r, out_valid_nxt;
  exec_res_t        out_r;

  assign s1_adv   = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r <= in_opcode_byte;
      s1_b1_r <= in_next_byte_one;
      s1_b2_r <= in_next_byte_two;
      s1_b3_r <= in_next_byte_three;
    end
  end

  xsx_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_fire),
    .rd_addr_a (in_next_byte_one[5:3]),
    .rd_addr_b (dst_index(in_opcode_byte, in_next_byte_one)),
    .rd_data_a (src_val),
    .rd_data_b (dst_val),
    .wr_en     (s1_fire && res.we),
    .wr_addr   (res.widx),
    .wr_data   (res.wval)
  );

  xsx_exec u_exec (
    .opcode_byte (s1_op_r),
    .byte_one    (s1_b1_r),
    .byte_two    (s1_b2_r),
    .byte_three  (s1_b3_r),
    .src_val     (src_val),
    .dst_val     (dst_val),
    .flags       (flags_r),
    .ip          (ip_r),
    .running     (running_r),
    .res         (res)
  );

  // Commit state as the instruction leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ip_r      <= PTR_RESET;
      flags_r   <= '0;
      running_r <= 1'b1;
    end else if (s1_fire) begin
      ip_r      <= res.next_ptr;
      flags_r   <= res.flags;
      running_r <= res.running;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_next_pointer = out_r.next_ptr;
  assign out_bytes_used   = out_r.used;
  assign out_write_enable = out_r.we;
  assign out_write_index  = out_r.widx;
  assign out_write_value  = out_r.wval;
  assign out_flags_word   = out_r.flags;

  // Once stopped, the core never restarts without reset
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |=> !running_r)
    else $error("running flag rose without reset");

  // A stopped core answers with the stopped status
  a_stopped_status: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !running_r) |=> (out_status == ST_STOPPED && !out_write_enable))
    else $error("stopped core produced a live result");

  // A register write only comes with an ok status
  a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_write_enable) |-> (out_status == ST_OK))
    else $error("register write with non-ok status");

  // Pointer moves only when an instruction commits
  a_ip_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(ip_r))
    else $error("instruction pointer changed without commit");

endmodule
`default_nettype wire

// ===== rtl/xsx_regfile.sv =====
// Eight-entry general register file: one write port, two registered read ports with bypass.
`default_nettype none
module xsx_regfile (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        rd_en,
  input  wire logic [xsx_pkg::IDX_W-1:0]   rd_addr_a,
  input  wire logic [xsx_pkg::IDX_W-1:0]   rd_addr_b,
  output logic      [xsx_pkg::REG_W-1:0]   rd_data_a,
  output logic      [xsx_pkg::REG_W-1:0]   rd_data_b,
  input  wire logic                        wr_en,
  input  wire logic [xsx_pkg::IDX_W-1:0]   wr_addr,
  input  wire logic [xsx_pkg::REG_W-1:0]   wr_data
);
  import xsx_pkg::*;

  logic [REG_W-1:0] mem_r [NREGS];
  logic [REG_W-1:0] rd_data_a_r;
  logic [REG_W-1:0] rd_data_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREGS; i++) begin
        mem_r[i] <= '0;
      end
    end else if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Forward a same-cycle write so the reader sees the newest value
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a_r <= (wr_en && wr_addr == rd_addr_a) ? wr_data : mem_r[rd_addr_a];
      rd_data_b_r <= (wr_en && wr_addr == rd_addr_b) ? wr_data : mem_r[rd_addr_b];
    end
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule
`default_nettype wire

// ===== rtl/xsx_exec.sv =====
// Combinational execute unit: decodes one instruction and computes result and state update.
`default_nettype none
module xsx_exec (
  input  wire logic [7:0]                  opcode_byte,
  input  wire logic [7:0]                  byte_one,
  input  wire logic [7:0]                  byte_two,
  input  wire logic [7:0]                  byte_three,
  input  wire logic [xsx_pkg::REG_W-1:0]   src_val,
  input  wire logic [xsx_pkg::REG_W-1:0]   dst_val,
  input  wire logic [xsx_pkg::REG_W-1:0]   flags,
  input  wire logic [xsx_pkg::PTR_W-1:0]   ip,
  input  wire logic                        running,
  output xsx_pkg::exec_res_t               res
);
  import xsx_pkg::*;

  status_t          status;
  logic [2:0]       used;
  logic             we;
  logic [REG_W-1:0] wval;
  logic [REG_W-1:0] flags_nxt;
  logic [PTR_W-1:0] disp;
  logic [REG_W-1:0] imm;
  logic [REG_W-1:0] diff;
  logic [IDX_W-1:0] widx;

  assign widx = dst_index(opcode_byte, byte_one);
  assign diff = dst_val - src_val;

  always_comb begin
    status    = ST_OK;
    used      = 3'd1;
    we        = 1'b0;
    wval      = '0;
    flags_nxt = flags;
    disp      = '0;
    imm       = '0;
    priority if (opcode_byte == OP_ADD_RR || opcode_byte == OP_XOR_RR ||
                 opcode_byte == OP_CMP_RR) begin
      used = 3'd2;
      if (byte_one[7:6] != MOD_REG) begin
        status = ST_BAD_MOD;
      end else if (opcode_byte == OP_CMP_RR) begin
        flags_nxt = flags & ~(FLAG_ZF | FLAG_SF | FLAG_CF | FLAG_OF);
        if (diff == '0)              flags_nxt = flags_nxt | FLAG_ZF;
        if ((diff & SIGN_BIT) != '0) flags_nxt = flags_nxt | FLAG_SF;
        if (src_val > dst_val)       flags_nxt = flags_nxt | FLAG_CF;
      end else begin
        we   = 1'b1;
        wval = (opcode_byte == OP_ADD_RR) ? dst_val + src_val : dst_val ^ src_val;
      end
    end else if (opcode_byte == OP_ADD_AX || opcode_byte == OP_SUB_AX) begin
      used = 3'd3;
      we   = 1'b1;
      imm  = {byte_two, byte_one};
      wval = (opcode_byte == OP_ADD_AX) ? dst_val + imm : dst_val - imm;
    end else if (opcode_byte >= OP_INC_LO && opcode_byte <= OP_DEC_HI) begin
      we   = 1'b1;
      wval = (opcode_byte < OP_DEC_LO) ? dst_val + 16'd1 : dst_val - 16'd1;
    end else if (opcode_byte >= OP_MOV_LO && opcode_byte <= OP_MOV_HI) begin
      used = 3'd3;
      we   = 1'b1;
      wval = {byte_two, byte_one};
    end else if (opcode_byte == OP_GRP_I16 || opcode_byte == OP_GRP_I8) begin
      if (opcode_byte == OP_GRP_I16) begin
        used = 3'd4;
        imm  = {byte_three, byte_two};
      end else begin
        used = 3'd3;
        imm  = {{8{byte_two[7]}}, byte_two};
      end
      if (byte_one >= MODRM_ADD_LO && byte_one <= MODRM_ADD_HI) begin
        we   = 1'b1;
        wval = dst_val + imm;
      end else if (byte_one >= MODRM_SUB_LO && byte_one <= MODRM_SUB_HI) begin
        we   = 1'b1;
        wval = dst_val - imm;
      end else begin
        status = ST_BAD_EXT;
      end
    end else if (opcode_byte == OP_JE || opcode_byte == OP_JMP) begin
      used = 3'd2;
      if (opcode_byte == OP_JMP || (flags & FLAG_ZF) != '0) begin
        disp = {{(PTR_W-8){byte_one[7]}}, byte_one};
      end
    end else if (opcode_byte == OP_NOP) begin
      status = ST_OK;
    end else if (opcode_byte == OP_HLT) begin
      status = ST_HALT;
    end else begin
      status = ST_BAD_OP;
    end

    // Drop everything once stopped: pointer and state hold
    if (!running) begin
      res.status   = ST_STOPPED;
      res.next_ptr = ip;
      res.used     = 3'd0;
      res.we       = 1'b0;
      res.widx     = '0;
      res.wval     = '0;
      res.flags    = flags;
      res.running  = 1'b0;
    end else begin
      res.status   = status;
      res.next_ptr = ip + PTR_W'(used) + disp;
      res.used     = used;
      res.we       = we;
      res.widx     = we ? widx : '0;
      res.wval     = we ? wval : '0;
      res.flags    = flags_nxt;
      res.running  = (status == ST_OK);
    end
  end

endmodule
`default_nettype wire
